>>> rtl/ddas_pkg.sv
// ----------------------------------------------------------------------------
// ddas_pkg
// Shared constants and types for the double-double plus double adder.
// ----------------------------------------------------------------------------
package ddas_pkg;

    localparam int          FADD_LAT  = 4;
    localparam int          NUM_LEVEL = 5;
    localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
    localparam logic [10:0] EXP_ONES  = 11'h7FF;

    typedef struct packed {
        logic        p;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] a;
        logic [63:0] s1;
        logic [63:0] x2;
        logic [63:0] y2;
        logic [63:0] x3;
        logic [63:0] y3;
        logic [63:0] x4;
    } t_ctx;

endpackage

>>> rtl/double_double_add_scalar_top.sv
// Pipeline: five adder levels of four stages each, plus the output register.
// Throughput: one beat per cycle; the whole pipeline stalls only while the
// output register holds a beat that is not taken.
// Reset: synchronous, active low; clears valid bits only.
// ----------------------------------------------------------------------------
// double_double_add_scalar_top
// Double-double plus double addition on a chain of pipelined binary64 adders.
// ----------------------------------------------------------------------------
module double_double_add_scalar_top import ddas_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,   // x_high, x_low, addend
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // sum_high, sum_low
);

    localparam int NSTG = NUM_LEVEL * FADD_LAT;

    logic        en;
    logic [NSTG-1:0] r_vld;
    logic        r_ovld;
    logic [127:0] r_odata;
    t_ctx        r_ctx [NUM_LEVEL][FADD_LAT];
    t_ctx        ctx_in [NUM_LEVEL];
    t_ctx        ctx_out [NUM_LEVEL];
    logic [63:0] xa [NUM_LEVEL];
    logic [63:0] xb [NUM_LEVEL];
    logic        xs [NUM_LEVEL];
    logic [63:0] xr [NUM_LEVEL];
    logic [63:0] y1r, y2r;
    logic        a_nan, h_nan;
    logic [63:0] fin_hi, fin_lo;

    assign en            = !r_ovld || m_axis_tready;
    assign s_axis_tready = en;

    always_comb begin
        a_nan = (s_axis_tdata[190:180] == EXP_ONES) && (s_axis_tdata[179:128] != 52'd0);
        h_nan = (s_axis_tdata[62:52] == EXP_ONES) && (s_axis_tdata[51:0] != 52'd0);
        ctx_in[0]    = '0;
        ctx_in[0].hi = s_axis_tdata[63:0];
        ctx_in[0].lo = s_axis_tdata[127:64];
        ctx_in[0].a  = s_axis_tdata[191:128];
        ctx_in[0].p  = !a_nan && !h_nan && (s_axis_tdata[190:128] > s_axis_tdata[62:0]);
        for (int l = 1; l < NUM_LEVEL; l++) begin
            ctx_in[l] = ctx_out[l-1];
        end
    end

    // lane X operands per level
    always_comb begin
        xa[0] = ctx_in[0].p ? ctx_in[0].a : ctx_in[0].lo;
        xb[0] = ctx_in[0].p ? ctx_in[0].hi : ctx_in[0].a;
        xs[0] = 1'b0;
        xa[1] = ctx_in[1].s1;
        xb[1] = ctx_in[1].a;
        xs[1] = 1'b1;
        xa[2] = ctx_in[2].p ? ctx_in[2].hi : ctx_in[2].lo;
        xb[2] = ctx_in[2].x2;
        xs[2] = 1'b1;
        xa[3] = ctx_in[3].p ? ctx_in[3].lo : ctx_in[3].s1;
        xb[3] = ctx_in[3].p ? ctx_in[3].x3 : ctx_in[3].y3;
        xs[3] = !ctx_in[3].p;
        xa[4] = ctx_in[4].x4;
        xb[4] = ctx_in[4].x3;
        xs[4] = 1'b0;
    end

    for (genvar l = 0; l < NUM_LEVEL; l++) begin : g_lane_x
        ddas_fadd u_fadd (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (xa[l]),
            .i_b   (xb[l]),
            .i_sub (xs[l]),
            .o_sum (xr[l])
        );
    end

    ddas_fadd u_fadd_y1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (ctx_in[1].hi),
        .i_b   (ctx_in[1].s1),
        .i_sub (1'b0),
        .o_sum (y1r)
    );

    ddas_fadd u_fadd_y2 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (ctx_in[2].y2),
        .i_b   (ctx_in[2].hi),
        .i_sub (1'b1),
        .o_sum (y2r)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < NUM_LEVEL; l++) begin
                r_ctx[l][0] <= ctx_in[l];
                for (int k = 1; k < FADD_LAT; k++) begin
                    r_ctx[l][k] <= r_ctx[l][k-1];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < NUM_LEVEL; l++) begin
            ctx_out[l] = r_ctx[l][FADD_LAT-1];
        end
        ctx_out[0].s1 = xr[0];
        ctx_out[1].x2 = xr[1];
        ctx_out[1].y2 = y1r;
        ctx_out[2].x3 = xr[2];
        ctx_out[2].y3 = y2r;
        ctx_out[3].x4 = xr[3];
        fin_hi = ctx_out[4].p ? ctx_out[4].s1 : ctx_out[4].y2;
        fin_lo = ctx_out[4].p ? ctx_out[4].x4 : xr[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_vld  <= {r_vld[NSTG-2:0], s_axis_tvalid};
            r_ovld <= r_vld[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_odata <= {fin_lo, fin_hi};
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;

endmodule

>>> rtl/ddas_fadd.sv
// ----------------------------------------------------------------------------
// ddas_fadd
// Four-stage binary64 adder/subtractor, round to nearest even.
// Stages: unpack and swap, align and add, normalise, round and pack.
// ----------------------------------------------------------------------------
module ddas_fadd import ddas_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic        i_sub,
    output logic [63:0] o_sum
);

    // stage 1
    logic        b_s, a_nan, b_nan, a_inf, b_inf, swap;
    logic [63:0] big, sml;
    logic        n1_spec;
    logic [63:0] n1_sval;
    logic        r1_sl, r1_ss, r1_spec;
    logic [10:0] r1_el, r1_es;
    logic [52:0] r1_ml, r1_ms;
    logic [63:0] r1_sval;

    always_comb begin
        b_s   = i_b[63] ^ i_sub;
        a_nan = (i_a[62:52] == EXP_ONES) && (i_a[51:0] != 52'd0);
        b_nan = (i_b[62:52] == EXP_ONES) && (i_b[51:0] != 52'd0);
        a_inf = (i_a[62:52] == EXP_ONES) && (i_a[51:0] == 52'd0);
        b_inf = (i_b[62:52] == EXP_ONES) && (i_b[51:0] == 52'd0);
        swap  = i_b[62:0] > i_a[62:0];
        big   = swap ? {b_s, i_b[62:0]} : i_a;
        sml   = swap ? i_a : {b_s, i_b[62:0]};
        n1_spec = a_nan | b_nan | a_inf | b_inf;
        if (a_nan || b_nan || (a_inf && b_inf && (i_a[63] != b_s))) begin
            n1_sval = CANON_NAN;
        end else if (a_inf) begin
            n1_sval = {i_a[63], EXP_ONES, 52'd0};
        end else begin
            n1_sval = {b_s, EXP_ONES, 52'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sl   <= big[63];
            r1_ss   <= sml[63];
            r1_el   <= big[62:52];
            r1_es   <= sml[62:52];
            r1_ml   <= {big[62:52] != 11'd0, big[51:0]};
            r1_ms   <= {sml[62:52] != 11'd0, sml[51:0]};
            r1_spec <= n1_spec;
            r1_sval <= n1_sval;
        end
    end

    // stage 2
    logic [10:0] el, es, dd;
    logic [55:0] ml56, ms56, shd, sm;
    logic        st;
    logic [56:0] n2_sum;
    logic [56:0] r2_sum;
    logic [10:0] r2_e;
    logic        r2_sign, r2_zsign, r2_spec;
    logic [63:0] r2_sval;

    always_comb begin
        el   = (r1_el == 11'd0) ? 11'd1 : r1_el;
        es   = (r1_es == 11'd0) ? 11'd1 : r1_es;
        dd   = el - es;
        ml56 = {r1_ml, 3'b000};
        ms56 = {r1_ms, 3'b000};
        if (dd >= 11'd56) begin
            shd = 56'd0;
            st  = |r1_ms;
        end else begin
            shd = ms56 >> dd[5:0];
            st  = |(ms56 & ~({56{1'b1}} << dd[5:0]));
        end
        sm = {shd[55:1], shd[0] | st};
        if (r1_sl ^ r1_ss) begin
            n2_sum = {1'b0, ml56} - {1'b0, sm};
        end else begin
            n2_sum = {1'b0, ml56} + {1'b0, sm};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_sum   <= n2_sum;
            r2_e     <= el;
            r2_sign  <= r1_sl;
            r2_zsign <= r1_sl & r1_ss;
            r2_spec  <= r1_spec;
            r2_sval  <= r1_sval;
        end
    end

    // stage 3
    logic [5:0]  lz;
    logic [10:0] lim, shn;
    logic [55:0] n3_m;
    logic [11:0] n3_e;
    logic [55:0] r3_m;
    logic [11:0] r3_e;
    logic        r3_sign, r3_zsign, r3_zero, r3_spec;
    logic [63:0] r3_sval;

    always_comb begin
        lz = 6'd56;
        for (int i = 0; i < 56; i++) begin
            if (r2_sum[i]) lz = 6'(55 - i);
        end
        lim = r2_e - 11'd1;
        shn = ({5'd0, lz} > lim) ? lim : {5'd0, lz};
        if (r2_sum[56]) begin
            n3_m = {r2_sum[56:2], r2_sum[1] | r2_sum[0]};
            n3_e = {1'b0, r2_e} + 12'd1;
        end else begin
            n3_m = r2_sum[55:0] << shn;
            n3_e = {1'b0, r2_e} - {1'b0, shn};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_m     <= n3_m;
            r3_e     <= n3_e;
            r3_sign  <= r2_sign;
            r3_zsign <= r2_zsign;
            r3_zero  <= (r2_sum == 57'd0);
            r3_spec  <= r2_spec;
            r3_sval  <= r2_sval;
        end
    end

    // stage 4
    logic        inc;
    logic [53:0] mr;
    logic [51:0] frac;
    logic [12:0] e2;
    logic [10:0] expf;
    logic [63:0] n4_sum;
    logic [63:0] r4_sum;

    always_comb begin
        inc  = r3_m[2] & (r3_m[1] | r3_m[0] | r3_m[3]);
        mr   = {1'b0, r3_m[55:3]} + {53'd0, inc};
        frac = mr[53] ? mr[52:1] : mr[51:0];
        e2   = mr[53] ? ({1'b0, r3_e} + 13'd1) : {1'b0, r3_e};
        expf = (mr[53] | mr[52]) ? e2[10:0] : 11'd0;
        if (r3_spec) begin
            n4_sum = r3_sval;
        end else if (r3_zero) begin
            n4_sum = {r3_zsign, 63'd0};
        end else if (e2 >= 13'd2047) begin
            n4_sum = {r3_sign, EXP_ONES, 52'd0};
        end else begin
            n4_sum = {r3_sign, expf, frac};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_sum <= n4_sum;
        end
    end

    assign o_sum = r4_sum;

endmodule

>>> rtl/ddas_chk.sv
// ----------------------------------------------------------------------------
// ddas_chk
// Port-level checks for the double-double adder, bound to the top level.
// ----------------------------------------------------------------------------
module ddas_chk import ddas_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped or changed while stalled");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_nan_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[62:52] == EXP_ONES) && (m_axis_tdata[51:0] != 52'd0)
        |-> m_axis_tdata[63:0] == CANON_NAN)
        else $error("non-canonical NaN in high word");

    a_nan_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[126:116] == EXP_ONES)
        && (m_axis_tdata[115:64] != 52'd0)
        |-> m_axis_tdata[127:64] == CANON_NAN)
        else $error("non-canonical NaN in low word");

endmodule

bind double_double_add_scalar_top ddas_chk u_ddas_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> dv/ddas_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ddas_checker
// Watches both stream channels, computes the expected double-double sum of
// every accepted input beat with native real arithmetic and compares each
// output beat against the oldest pending sum.
// ----------------------------------------------------------------------------
module ddas_checker import ddas_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [191:0] i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [127:0] i_out_data,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct packed {
        logic [63:0] sum_low;
        logic [63:0] sum_high;
    } t_dd_sum;

    t_dd_sum pending_sums[$];
    int      fail_q = 0;
    int      pend_q = 0;

    function automatic logic [63:0] canon(input real r);
        logic [63:0] w;
        begin
            w = $realtobits(r);
            if (w[62:52] == EXP_ONES && w[51:0] != 52'd0) begin
                w = CANON_NAN;
            end
            return w;
        end
    endfunction

    function automatic t_dd_sum dd_plus_double(input logic [63:0] xh_w,
                                               input logic [63:0] xl_w,
                                               input logic [63:0] ad_w);
        real xh, xl, ad, sh, sl, t, r, part, t1, lr, t2, hr;
        t_dd_sum res;
        begin
            xh = $bitstoreal(xh_w);
            xl = $bitstoreal(xl_w);
            ad = $bitstoreal(ad_w);
            if ($bitstoreal({1'b0, ad_w[62:0]}) > $bitstoreal({1'b0, xh_w[62:0]})) begin
                sh = ad + xh;
                t  = sh - ad;
                r  = xh - t;
                sl = xl + r;
            end else begin
                part = xl + ad;
                t1   = part - ad;
                lr   = xl - t1;
                sh   = xh + part;
                t2   = sh - xh;
                hr   = part - t2;
                sl   = lr + hr;
            end
            res.sum_high = canon(sh);
            res.sum_low  = canon(sl);
            return res;
        end
    endfunction

    assign o_fail_count = fail_q;
    assign o_pending    = pend_q;

    always @(posedge i_clk) begin
        t_dd_sum exp_sum;
        int      n_err;
        n_err = 0;
        if (i_rst_n && i_in_valid && i_in_ready) begin
            pending_sums.push_back(dd_plus_double(i_in_data[63:0], i_in_data[127:64],
                                                  i_in_data[191:128]));
        end
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (pending_sums.size() == 0) begin
                $error("unexpected beat: sum_high %h sum_low %h",
                       i_out_data[63:0], i_out_data[127:64]);
                n_err = n_err + 1;
            end else begin
                exp_sum = pending_sums.pop_front();
                if (exp_sum.sum_high !== i_out_data[63:0]) begin
                    $error("sum_high: expected %h actual %h",
                           exp_sum.sum_high, i_out_data[63:0]);
                    n_err = n_err + 1;
                end
                if (exp_sum.sum_low !== i_out_data[127:64]) begin
                    $error("sum_low: expected %h actual %h",
                           exp_sum.sum_low, i_out_data[127:64]);
                    n_err = n_err + 1;
                end
            end
        end
        fail_q <= fail_q + n_err;
        pend_q = pending_sums.size();
    end
endmodule

>>> dv/double_double_add_scalar_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_double_add_scalar_top_test
// Drives directed and random double-double plus double operands, including
// zeros, infinities, NaNs, subnormals and near-cancelling values, with random
// gaps and back-pressure; the checker judges every output beat.
// ----------------------------------------------------------------------------
module double_double_add_scalar_top_test import ddas_pkg::*;;

    localparam int NUM_RANDOM = 1000;
    localparam int CYCLE_LIMIT = 400000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata = '0;   // x_high, x_low, addend
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;        // sum_high, sum_low
    int           fail_count;
    int           pending;
    int           cycle_count = 0;
    bit           sink_hold = 1'b0;

    always #10 i_clk = ~i_clk;

    double_double_add_scalar_top u_dut (.*);

    ddas_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("double_double_add_scalar_top test failed");
            $finish;
        end
    end

    // sink: random stalls, or a long hold-off when asked
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = $urandom_range(0, 9);
            if (sink_hold) begin
                m_axis_tready <= 1'b0;
                repeat (200) @(negedge i_clk);
                sink_hold = 1'b0;
            end else if (gap < 4 || $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    end

    function automatic logic [63:0] pick_word(input logic [63:0] near);
        logic [63:0] w;
        begin
            w = {$urandom, $urandom};
            case ($urandom_range(0, 9))
                0: w[62:52] = EXP_ONES;
                1: w[62:52] = 11'd0;
                2: w = {w[63], EXP_ONES, 52'd0};
                3: w = {w[63], 63'd0};
                4: w = {~near[63], near[62:0]};
                5: w[62:52] = near[62:52] - 11'($urandom_range(0, 60));
                6: w[62:52] = near[62:52] + 11'($urandom_range(0, 3));
                default: w[62:52] = 11'd1023 + 11'($urandom_range(0, 40)) - 11'd20;
            endcase
            return w;
        end
    endfunction

    task automatic send_beat(input logic [63:0] xh, input logic [63:0] xl,
                             input logic [63:0] ad, input bit no_gap);
        int gap;
        begin
            gap = no_gap ? 0 : $urandom_range(0, 9);
            if (gap > 0 && $urandom_range(0, 4) == 0) gap = 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {ad, xl, xh};
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            @(negedge i_clk);
        end
    endtask

    initial begin
        logic [63:0] xh, xl, ad;
        logic [63:0] dir_xh[14] = '{
            64'h3FF0000000000000, 64'h3FF0000000000000, 64'h7FF0000000000000,
            64'h7FF0000000000000, 64'h0000000000000000, 64'h8000000000000000,
            64'h7FF4000000000001, 64'h3FF0000000000000, 64'h7FEFFFFFFFFFFFFF,
            64'h0000000000000001, 64'hFFFFFFFFFFFFFFFF, 64'h4000000000000000,
            64'h3FF0000000000000, 64'h0000000000000000};
        logic [63:0] dir_xl[14] = '{
            64'h3C90000000000000, 64'h0000000000000000, 64'h0000000000000000,
            64'h0000000000000000, 64'h8000000000000000, 64'h8000000000000000,
            64'h0000000000000000, 64'hFFF0000000000001, 64'h7C9FFFFFFFFFFFFF,
            64'h8000000000000001, 64'hFFFFFFFFFFFFFFFF, 64'hBCA0000000000000,
            64'h3C90000000000000, 64'h0000000000000000};
        logic [63:0] dir_ad[14] = '{
            64'h4000000000000000, 64'hBFF0000000000000, 64'hFFF0000000000000,
            64'h7FF0000000000000, 64'h0000000000000000, 64'h8000000000000000,
            64'h3FF0000000000000, 64'h7FF8000000000000, 64'h7FEFFFFFFFFFFFFF,
            64'h000FFFFFFFFFFFFF, 64'h0000000000000000, 64'hC000000000000000,
            64'hBFF0000000000000, 64'hFFFFFFFFFFFFFFFF};
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int i = 0; i < 14; i++) send_beat(dir_xh[i], dir_xl[i], dir_ad[i], 1'b0);
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i == 300) sink_hold = 1'b1;
            if (i == 600) begin
                s_axis_tvalid <= 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            xh = pick_word(64'h3FF0000000000000);
            xl = pick_word({xh[63], xh[62:52] - 11'd53, xh[51:0]});
            ad = pick_word(xh);
            send_beat(xh, xl, ad, (i >= 300 && i < 330));
        end
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("double_double_add_scalar_top test passed");
        end else begin
            $display("double_double_add_scalar_top test failed");
        end
        $finish;
    end
endmodule
